### hw/rtl/lidar_clear_direction_picker_macros.svh
// assertion macros for the lidar clear direction picker
`ifndef LIDAR_CLEAR_DIRECTION_PICKER_MACROS_SVH
`define LIDAR_CLEAR_DIRECTION_PICKER_MACROS_SVH

// same-cycle implication, checked outside reset
`define LCDP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define LCDP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/lcdp_pkg.sv
// constants and candidate target tables for the lidar clear direction picker
package lcdp_pkg;

   localparam int ANGLE_W   = 16;
   localparam int QUARTER_W = 14;
   localparam int DIST_IN_W = 16;
   localparam int RADIUS_W  = 12;
   localparam int CAND_W    = 3;
   localparam int DIR_W     = 3;
   localparam int CAND_MAX  = 7;
   localparam int OPND_W    = 17;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int DIST_W    = 38;
   localparam int SINE_W    = 16;

   localparam logic [ANGLE_W-1:0]  QUARTER_TURN    = 16'h4000;
   localparam logic [RADIUS_W-1:0] CLEARANCE_RESET = 12'd300;
   localparam logic [63:0]         PI_Q30          = 64'd3373259426;

   localparam logic [DIR_W-1:0] DIR_IDLE          = 3'd0;
   localparam logic [DIR_W-1:0] DIR_FORWARD       = 3'd1;
   localparam logic [DIR_W-1:0] DIR_FORWARD_LEFT  = 3'd2;
   localparam logic [DIR_W-1:0] DIR_FORWARD_RIGHT = 3'd3;
   localparam logic [DIR_W-1:0] DIR_RIGHT         = 3'd4;
   localparam logic [DIR_W-1:0] DIR_LEFT          = 3'd5;
   localparam logic [DIR_W-1:0] DIR_BACK          = 3'd6;

   localparam logic [CAND_W-1:0] CAND_NONE = 3'd7;

   // taylor series divisors (2n)(2n+1) for n = 1..10
   localparam logic [63:0] SERIES_DIV [10] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
      64'd156, 64'd210, 64'd272, 64'd342, 64'd420
   };

   localparam logic signed [OPND_W-1:0] TARGET_X [CAND_MAX] = '{
      17'sd0, -17'sd140, 17'sd140, 17'sd0, 17'sd150, -17'sd150, 17'sd0
   };

   localparam logic signed [OPND_W-1:0] TARGET_Y [CAND_MAX] = '{
      17'sd600, 17'sd300, 17'sd300, 17'sd150, 17'sd0, 17'sd0, -17'sd150
   };

   // tx*tx + ty*ty per target
   localparam logic signed [DIST_W-1:0] TARGET_R2 [CAND_MAX] = '{
      38'sd360000, 38'sd109600, 38'sd109600, 38'sd22500,
      38'sd22500, 38'sd22500, 38'sd22500
   };

   localparam logic [DIR_W-1:0] TARGET_DIR [CAND_MAX] = '{
      DIR_FORWARD, DIR_FORWARD_LEFT, DIR_FORWARD_RIGHT, DIR_FORWARD,
      DIR_RIGHT, DIR_LEFT, DIR_BACK
   };

endpackage

### hw/rtl/lidar_clear_direction_picker.sv
// One lidar sample is taken per req_ transfer and occupies the block from
// S_SIN through S_FIN, with S_DOTY, S_DOTS and S_TEST run once per candidate;
// req_stall holds off the next sample until the block is back in S_IDLE. The
// order of the steps follows from the use of one shared 17x17 multiplier
// that forms both coordinates, their squares, the squared clearance radius
// and, per candidate, the two dot product terms, plus two reads of the
// registered quarter-wave sine rom. Only a sample marked last_sample yields a
// rsp_ transfer; it names the first clear candidate and the scan minimum, and
// the scan state is cleared. The next sample may be accepted while that
// result still waits, but a later last_sample holds in its final cycle for as
// long as the earlier result is still stalled on rsp_. csr_ writes set the
// clearance radius and are taken at any time, but belong between samples.
`include "lidar_clear_direction_picker_macros.svh"

module lidar_clear_direction_picker #(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int CANDIDATE_COUNT  = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lcdp_pkg::DIST_IN_W-1:0]    req_sample_distance,
   input  logic [lcdp_pkg::ANGLE_W-1:0]      req_sample_angle,
   input  logic                              req_last_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lcdp_pkg::CAND_W-1:0]       rsp_chosen_candidate,
   output logic [lcdp_pkg::DIR_W-1:0]        rsp_direction,
   output logic [lcdp_pkg::DIST_IN_W-1:0]    rsp_min_distance,
   output logic [lcdp_pkg::ANGLE_W-1:0]      rsp_min_angle,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lcdp_pkg::RADIUS_W-1:0]     csr_clearance_radius
);
   import lcdp_pkg::*;

   localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
   localparam int SCALE_W = QUARTER_W + $clog2(SINE_TABLE_DEPTH + 1);
   localparam logic [63:0] SINE_QUAD_DIV = 64'(4 * SINE_TABLE_DEPTH);
   localparam logic [SCALE_W-1:0] DEPTH_MUL = SCALE_W'(SINE_TABLE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SINE_TABLE_DEPTH - 1);
   localparam logic [CAND_W-1:0] LAST_CAND = CAND_W'(CANDIDATE_COUNT - 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SIN  = 4'd1;
   localparam logic [3:0] S_COS  = 4'd2;
   localparam logic [3:0] S_YRND = 4'd3;
   localparam logic [3:0] S_XRND = 4'd4;
   localparam logic [3:0] S_XSQ  = 4'd5;
   localparam logic [3:0] S_YSQ  = 4'd6;
   localparam logic [3:0] S_SUM  = 4'd7;
   localparam logic [3:0] S_DOTY = 4'd8;
   localparam logic [3:0] S_DOTS = 4'd9;
   localparam logic [3:0] S_TEST = 4'd10;
   localparam logic [3:0] S_FIN  = 4'd11;

   typedef logic [SINE_W-1:0] rom_type [SINE_TABLE_DEPTH];

   function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      int n;
      x = (PI_Q30 * 64'(2 * k + 1)) / SINE_QUAD_DIV;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (n = 1; n <= 10; n++) begin
         term = ((term * x2) >> 30) / SERIES_DIV[n-1];
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return SINE_W'((sum * 64'd32767 + 64'd536870912) >> 30);
   endfunction

   function automatic rom_type build_rom();
      rom_type t;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         t[k] = sine_entry(k);
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   function automatic logic [IDX_W-1:0] sine_index(input logic [ANGLE_W-1:0] ang);
      logic [SCALE_W-1:0] scaled;
      logic [IDX_W-1:0]   idx;
      scaled = SCALE_W'(ang[QUARTER_W-1:0]) * DEPTH_MUL;
      idx = IDX_W'(scaled >> QUARTER_W);
      return ang[QUARTER_W] ? IDX_LAST - idx : idx;
   endfunction

   function automatic logic signed [OPND_W-1:0] round_q15(
      input logic signed [PROD_W-1:0] p,
      input logic                     neg
   );
      logic [OPND_W-1:0] mag;
      mag = OPND_W'((p[31:0] + 32'd16384) >> 15);
      return neg ? $signed(OPND_W'(-mag)) : $signed(mag);
   endfunction

   logic [3:0]                  state_ff, state_in;
   logic [CAND_W-1:0]           cand_ff, cand_in;
   logic [CANDIDATE_COUNT-1:0]  blocked_ff, blocked_in;
   logic                        near_valid_ff, near_valid_in;
   logic [DIST_IN_W-1:0]        near_dist_ff, near_dist_in;
   logic [ANGLE_W-1:0]          near_angle_ff, near_angle_in;
   logic [RADIUS_W-1:0]         radius_ff, radius_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CAND_W-1:0]           rsp_cand_ff, rsp_cand_in;
   logic [DIR_W-1:0]            rsp_dir_ff, rsp_dir_in;
   logic [DIST_IN_W-1:0]        rsp_dist_ff, rsp_dist_in;
   logic [ANGLE_W-1:0]          rsp_angle_ff, rsp_angle_in;

   logic [DIST_IN_W-1:0]        dist_ff, dist_in;
   logic [ANGLE_W-1:0]          angle_ff, angle_in;
   logic                        last_ff, last_in;
   logic signed [OPND_W-1:0]    x_ff, x_in;
   logic signed [OPND_W-1:0]    y_ff, y_in;
   logic signed [DIST_W-1:0]    ssq_ff, ssq_in;
   logic signed [DIST_W-1:0]    dot_ff, dot_in;
   logic signed [DIST_W-1:0]    r2_ff, r2_in;
   logic signed [PROD_W-1:0]    prod_ff;
   logic [SINE_W-1:0]           rom_q_ff;

   logic [ANGLE_W-1:0]          cos_angle;
   logic [IDX_W-1:0]            rom_addr;
   logic signed [OPND_W-1:0]    mul_a;
   logic signed [OPND_W-1:0]    mul_b;
   logic [CAND_W-1:0]           next_cand;
   logic signed [DIST_W-1:0]    test_lhs;
   logic                        test_hit;
   logic [CAND_W-1:0]           pick;
   logic [DIR_W-1:0]            pick_dir;
   logic                        req_xfer;
   logic                        rsp_xfer;
   logic                        rsp_free;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_chosen_candidate = rsp_cand_ff;
   assign rsp_direction        = rsp_dir_ff;
   assign rsp_min_distance     = rsp_dist_ff;
   assign rsp_min_angle        = rsp_angle_ff;

   assign cos_angle = angle_ff + QUARTER_TURN;
   assign rom_addr  = sine_index((state_ff == S_SIN) ? angle_ff : cos_angle);
   assign next_cand = (cand_ff == LAST_CAND) ? cand_ff : cand_ff + CAND_W'(1);

   // distance squared to the target: x^2 + y^2 - 2*dot + tx^2 + ty^2
   assign test_lhs = ssq_ff + TARGET_R2[cand_ff] - (dot_ff <<< 1);
   assign test_hit = (test_lhs < r2_ff) && !dot_ff[DIST_W-1] && (dot_ff != '0);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_COS, S_YRND: begin
            mul_a = $signed({1'b0, dist_ff});
            mul_b = $signed({1'b0, rom_q_ff});
         end
         S_XRND: begin
            mul_a = $signed(OPND_W'(radius_ff));
            mul_b = $signed(OPND_W'(radius_ff));
         end
         S_XSQ: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         S_YSQ: begin
            mul_a = y_ff;
            mul_b = y_ff;
         end
         S_SUM: begin
            mul_a = TARGET_X[cand_ff];
            mul_b = x_ff;
         end
         S_TEST: begin
            mul_a = TARGET_X[next_cand];
            mul_b = x_ff;
         end
         S_DOTY: begin
            mul_a = TARGET_Y[cand_ff];
            mul_b = y_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // first clear candidate
   always_comb begin
      pick     = CAND_NONE;
      pick_dir = DIR_IDLE;
      for (int i = CANDIDATE_COUNT - 1; i >= 0; i--) begin
         if (!blocked_ff[i]) begin
            pick     = CAND_W'(i);
            pick_dir = TARGET_DIR[i];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      cand_in       = cand_ff;
      blocked_in    = blocked_ff;
      near_valid_in = near_valid_ff;
      near_dist_in  = near_dist_ff;
      near_angle_in = near_angle_ff;
      radius_in     = radius_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_xfer;
      rsp_cand_in   = rsp_cand_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_angle_in  = rsp_angle_ff;
      dist_in       = dist_ff;
      angle_in      = angle_ff;
      last_in       = last_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      ssq_in        = ssq_ff;
      dot_in        = dot_ff;
      r2_in         = r2_ff;

      if (csr_valid && csr_ready) begin
         radius_in = csr_clearance_radius;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               dist_in  = req_sample_distance;
               angle_in = req_sample_angle;
               last_in  = req_last_sample;
               cand_in  = '0;
               state_in = S_SIN;
            end
         end
         S_SIN: begin
            if (!near_valid_ff || dist_ff < near_dist_ff) begin
               near_dist_in  = dist_ff;
               near_angle_in = angle_ff;
               near_valid_in = 1'b1;
            end
            state_in = S_COS;
         end
         S_COS: begin
            state_in = S_YRND;
         end
         S_YRND: begin
            y_in     = round_q15(prod_ff, angle_ff[ANGLE_W-1]);
            state_in = S_XRND;
         end
         S_XRND: begin
            x_in     = round_q15(prod_ff, cos_angle[ANGLE_W-1]);
            state_in = S_XSQ;
         end
         S_XSQ: begin
            r2_in    = DIST_W'(prod_ff);
            state_in = S_YSQ;
         end
         S_YSQ: begin
            ssq_in   = DIST_W'(prod_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            ssq_in   = ssq_ff + DIST_W'(prod_ff);
            state_in = S_DOTY;
         end
         S_DOTY: begin
            dot_in   = DIST_W'(prod_ff);
            state_in = S_DOTS;
         end
         S_DOTS: begin
            dot_in   = dot_ff + DIST_W'(prod_ff);
            state_in = S_TEST;
         end
         S_TEST: begin
            if (test_hit) begin
               blocked_in[cand_ff] = 1'b1;
            end
            if (cand_ff == LAST_CAND) begin
               state_in = S_FIN;
            end else begin
               cand_in  = next_cand;
               state_in = S_DOTY;
            end
         end
         S_FIN: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cand_in   = pick;
               rsp_dir_in    = pick_dir;
               rsp_dist_in   = near_dist_ff;
               rsp_angle_in  = near_angle_ff;
               blocked_in    = '0;
               near_valid_in = 1'b0;
               near_dist_in  = '1;
               near_angle_in = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cand_ff       <= '0;
         blocked_ff    <= '0;
         near_valid_ff <= 1'b0;
         near_dist_ff  <= '1;
         near_angle_ff <= '0;
         radius_ff     <= CLEARANCE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cand_ff       <= cand_in;
         blocked_ff    <= blocked_in;
         near_valid_ff <= near_valid_in;
         near_dist_ff  <= near_dist_in;
         near_angle_ff <= near_angle_in;
         radius_ff     <= radius_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cand_ff  <= rsp_cand_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_angle_ff <= rsp_angle_in;
      dist_ff      <= dist_in;
      angle_ff     <= angle_in;
      last_ff      <= last_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      ssq_ff       <= ssq_in;
      dot_ff       <= dot_in;
      r2_ff        <= r2_in;
      prod_ff      <= mul_a * mul_b;
   end

   // quarter-wave sine rom, registered read
   always_ff @(posedge clock) begin
      rom_q_ff <= SINE_ROM[rom_addr];
   end

   `LCDP_ASSERT_NOW(a_cand_range, 1'b1, cand_ff <= LAST_CAND,
      "candidate counter out of range")
   `LCDP_ASSERT_NEXT(a_accept_starts, req_xfer, state_ff == S_SIN,
      "accepted sample did not start the sequence")
   `LCDP_ASSERT_NEXT(a_scan_clear, state_ff == S_FIN && last_ff && rsp_free,
      rsp_valid_ff && blocked_ff == '0 && !near_valid_ff,
      "end of scan did not post a result and clear the scan state")
   `LCDP_ASSERT_NOW(a_none_is_idle, rsp_valid_ff,
      (rsp_cand_ff == CAND_NONE) == (rsp_dir_ff == DIR_IDLE),
      "chosen candidate and direction disagree")
   `LCDP_ASSERT_NEXT(a_hold_when_full,
      state_ff == S_FIN && last_ff && !rsp_free, state_ff == S_FIN,
      "result overwritten while the previous one is pending")

endmodule
